FILE: hdl/dmx_gamma_led_dimmer_defines.svh
// Assertion macros shared by the dimmer RTL
`ifndef DMX_GAMMA_LED_DIMMER_DEFINES_SVH
`define DMX_GAMMA_LED_DIMMER_DEFINES_SVH

// Implication check, reset disables
`define DMX_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dimmer check failed");

// Next-cycle implication check, reset disables
`define DMX_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dimmer check failed");

`endif

FILE: hdl/dgld_pkg.sv
// ----------------------------------------------------------------------------
// dgld_pkg
// Shared constants and tables for the gamma-corrected dimmer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgld_pkg;

  localparam int NumColoursDefault = 6;
  localparam int FracBits          = 28;
  localparam int NumLimitRegs      = 6;
  localparam logic [11:0] GammaReset = 12'd563;
  localparam logic [7:0]  LimitReset = 8'd255;

  // Register indexes
  localparam logic [2:0] RegGamma  = 3'd0;
  localparam logic [2:0] RegLimit0 = 3'd1;

  // Truncated integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt_const(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 64'd0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 in Q.28 by repeated squaring of a Q1.31 mantissa, elaboration only
  function automatic logic [33:0] log2_q28_const(input logic [31:0] p);
    logic [4:0]   ev;
    logic [63:0]  zv;
    logic [127:0] sq;
    logic [27:0]  fr;
    ev = '0;
    for (int i = 0; i < 32; i++)
      if (p[i]) ev = 5'(i);
    zv = 64'(p) << (31 - ev);
    fr = '0;
    for (int j = 0; j < FracBits; j++) begin
      sq = 128'(zv) * 128'(zv);
      zv = sq[94:31];
      fr = {fr[26:0], 1'b0};
      if (zv >= 64'h1_0000_0000) begin
        fr[0] = 1'b1;
        zv = zv >> 1;
      end
    end
    return {1'b0, ev, fr};
  endfunction

  // Chain of 2^-(2^-k) in Q0.32, entry 0 holds k = 1
  function automatic logic [32*FracBits-1:0] exp_table_const();
    logic [32*FracBits-1:0] t;
    logic [63:0]            c;
    t = '0;
    c = isqrt_const(64'd1 << 63);
    for (int i = 0; i < FracBits; i++) begin
      t[32*i +: 32] = c[31:0];
      c = isqrt_const({c[31:0], 32'd0});
    end
    return t;
  endfunction

  // log2(255^3) in Q.28
  localparam logic [33:0] Log2Cube = log2_q28_const(32'd16581375);

  localparam logic [32*FracBits-1:0] ExpTable = exp_table_const();

  // 2^-(2^-k) in Q0.32, k = 1..28; index 0 holds k = 1
  function automatic logic [31:0] exp_const(input logic [4:0] idx);
    logic [31:0] c;
    if (idx < 5'(FracBits)) c = ExpTable[32*idx +: 32];
    else c = 32'hFFFF_FFFF;
    return c;
  endfunction

endpackage

FILE: hdl/dmx_gamma_led_dimmer.sv
// ----------------------------------------------------------------------------
// dmx_gamma_led_dimmer
// DMX slot writes in, gamma-corrected 16-bit PWM compare values out.
// ----------------------------------------------------------------------------
// Input beats carry {level, slot}. Slot 0 sets the master level, slots 1 to
// NUM_COLOURS set colour levels; other slots and unchanged levels are dropped.
// Output beats carry {compare_value, pwm_index} in tdata and last_of_run in
// tlast. A colour change gives one beat; a master change gives one beat per
// nonzero colour in ascending order with tlast on the final one.
// Each result runs through one shared 33x33 multiplier under a sequencer:
// product (level times master, then times limit), log2 setup, 28
// squarings, gamma scale, 28 exp steps, final scale and output load; a zero
// product skips from the log2 setup to the output load. A master change adds
// a scan step before each result. The input is ready only in idle, so no new
// slot write is taken until the current result or run is loaded for output. The
// result waits in the output register and the sequencer holds in the output
// load while the receiver stalls. Reset clears all levels, sets gamma to
// 563 and limits to 255, and empties the output register.
// Configuration is written through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dmx_gamma_led_dimmer_defines.svh"

module dmx_gamma_led_dimmer #(
  parameter int NUM_COLOURS = dgld_pkg::NumColoursDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [8:0] slot, [16:9] level, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] pwm_index, [18:3] compare_value
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import dgld_pkg::*;

  localparam int CW = (NUM_COLOURS > 1) ? $clog2(NUM_COLOURS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_P1 = 4'd2,
                         S_P2 = 4'd3, S_LOGI = 4'd4, S_LSQ = 4'd5,
                         S_GAM = 4'd6, S_EXP = 4'd7, S_FIN = 4'd8,
                         S_OUT = 4'd9;

  logic [3:0]  state;
  logic [11:0] gamma_q8;
  logic [7:0]  limits [NUM_COLOURS];
  logic [7:0]  master_level;
  logic [7:0]  colour_levels [NUM_COLOURS];
  logic [CW-1:0] ch;
  logic        master_run;
  logic [23:0] prod;
  logic [32:0] z;
  logic [4:0]  e, k;
  logic [27:0] frac;
  logic [36:0] lval;
  logic [32:0] acc;
  logic [5:0]  nshift;
  logic [15:0] result;

  // Shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [8:0] in_slot;
  logic [7:0] in_level;
  assign in_slot  = s_tdata[8:0];
  assign in_level = s_tdata[16:9];

  // Find next nonzero colour at or after ch
  logic          any_next;
  logic [CW-1:0] next_ch;
  always_comb begin
    any_next = 1'b0;
    next_ch  = '0;
    for (int i = NUM_COLOURS - 1; i >= 0; i--) begin
      if (CW'(i) >= ch && colour_levels[i] != 8'd0) begin
        any_next = 1'b1;
        next_ch  = CW'(i);
      end
    end
  end

  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < NUM_COLOURS; i++)
      if (CW'(i) > ch && colour_levels[i] != 8'd0) more_after = 1'b1;
  end

  // MSB position of prod
  logic [4:0] msb;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 24; i++)
      if (prod[i]) msb = 5'(i);
  end

  logic [33:0] ylog;
  assign ylog = Log2Cube - {e, frac};

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P1:  begin mul_a = 33'(colour_levels[ch]); mul_b = 33'(master_level); end
      S_P2:  begin mul_a = 33'(prod); mul_b = 33'(limits[ch]); end
      S_LSQ: begin mul_a = z; mul_b = z; end
      S_GAM: begin mul_a = 33'(ylog); mul_b = 33'(gamma_q8); end
      S_EXP: begin mul_a = acc; mul_b = 33'(exp_const(k)); end
      S_FIN: begin mul_a = acc >> nshift; mul_b = 33'd65535; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_q8 <= GammaReset;
      for (int i = 0; i < NUM_COLOURS; i++) limits[i] <= LimitReset;
    end else if (cfg_we) begin
      if (cfg_index == RegGamma) gamma_q8 <= cfg_data;
      for (int i = 0; i < NUM_COLOURS && i < NumLimitRegs; i++)
        if (cfg_index == RegLimit0 + 3'(i)) limits[i] <= cfg_data[7:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      master_level <= '0;
      for (int i = 0; i < NUM_COLOURS; i++) colour_levels[i] <= '0;
      m_tvalid     <= 1'b0;
      ch           <= '0;
      master_run   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (in_slot == 9'd0) begin
              if (in_level != master_level) begin
                master_level <= in_level;
                master_run   <= 1'b1;
                ch           <= '0;
                state        <= S_SCAN;
              end
            end else if (in_slot <= 9'(NUM_COLOURS)) begin
              if (in_level != colour_levels[CW'(in_slot - 9'd1)]) begin
                colour_levels[CW'(in_slot - 9'd1)] <= in_level;
                master_run <= 1'b0;
                ch         <= CW'(in_slot - 9'd1);
                state      <= S_P1;
              end
            end
          end
        end
        S_SCAN: begin
          if (any_next) begin
            ch    <= next_ch;
            state <= S_P1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_P1: begin
          prod  <= mul_p[23:0];
          state <= S_P2;
        end
        S_P2: begin
          prod  <= mul_p[23:0];
          state <= S_LOGI;
        end
        S_LOGI: begin
          if (prod == 24'd0) begin
            result <= '0;
            state  <= S_OUT;
          end else begin
            e     <= msb;
            z     <= 33'({prod, 31'd0} >> msb);
            frac  <= '0;
            k     <= '0;
            state <= S_LSQ;
          end
        end
        S_LSQ: begin
          if (mul_p[63]) begin
            z    <= mul_p[64:32];
            frac <= {frac[26:0], 1'b1};
          end else begin
            z    <= mul_p[63:31];
            frac <= {frac[26:0], 1'b0};
          end
          k <= k + 5'd1;
          if (k == 5'(FracBits - 1)) state <= S_GAM;
        end
        S_GAM: begin
          lval  <= mul_p[44:8];
          acc   <= 33'h1_0000_0000;
          k     <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (lval[27 - k]) acc <= mul_p[64:32];
          k <= k + 5'd1;
          if (k == 5'(FracBits - 1)) begin
            nshift <= (lval[36:28] > 9'd32) ? 6'd33 : lval[33:28];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          result <= mul_p[47:32];
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, result, 3'(ch)};
            m_tlast  <= !master_run || !more_after;
            if (master_run && more_after) begin
              ch    <= ch + CW'(1);
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DMX_ASSERT_IMPL(a_busy_not_ready, clk, rst, state != S_IDLE, !s_tready)
  `DMX_ASSERT_NEXT(a_hold_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DMX_ASSERT_IMPL(a_index_range, clk, rst, m_tvalid, m_tdata[2:0] < 3'(NUM_COLOURS) || NUM_COLOURS > 7)
endmodule

FILE: tb/sv/tb_dmx_gamma_led_dimmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dmx_gamma_led_dimmer
// Streams DMX slot writes into the dimmer and checks every PWM compare beat
// against a fixed-point model of the gamma curve, with random backpressure.
// ----------------------------------------------------------------------------

class dimmer_scoreboard;
  typedef struct {
    bit [2:0]  pwm_index;
    bit [15:0] compare_value;
    bit        last_of_run;
  } pwm_update_t;

  pwm_update_t pending_updates[$];
  bit [11:0]   gamma_q8;
  bit [7:0]    limit[6];
  bit [7:0]    master;
  bit [7:0]    colour[6];
  bit [63:0]   root_consts[28];
  int          errors;

  function new();
    gamma_q8 = dgld_pkg::GammaReset;
    master = 0;
    errors = 0;
    for (int i = 0; i < 6; i++) begin
      limit[i] = dgld_pkg::LimitReset;
      colour[i] = 0;
    end
    root_consts[0] = isqrt(64'd1 << 63);
    for (int i = 1; i < 28; i++) root_consts[i] = isqrt(root_consts[i - 1] << 32);
  endfunction

  function bit [63:0] isqrt(bit [63:0] a);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2 in Q.28 by repeated squaring of a Q1.31 mantissa
  function bit [63:0] log2_fix(bit [31:0] p);
    bit [63:0]  e;
    bit [63:0]  z;
    bit [63:0]  frac;
    bit [127:0] sq;
    e = 0;
    frac = 0;
    while (e < 31 && (p >> (e + 1)) != 0) e++;
    z = {32'd0, p} << (31 - e);
    for (int k = 0; k < 28; k++) begin
      sq = {64'd0, z} * {64'd0, z};
      z = sq[94:31];
      frac <<= 1;
      if (z >= (64'd1 << 32)) begin
        frac |= 1;
        z >>= 1;
      end
    end
    return (e << 28) | frac;
  endfunction

  function bit [15:0] gamma_value(bit [7:0] v, bit [7:0] m, bit [7:0] imax);
    bit [31:0]  p;
    bit [63:0]  l;
    bit [63:0]  y;
    bit [63:0]  n;
    bit [63:0]  acc;
    bit [127:0] prod;
    bit [63:0]  scaled;
    p = v * m * imax;
    if (p == 0) return 0;
    l = log2_fix(32'd16581375) - log2_fix(p);
    y = (l * gamma_q8) >> 8;
    n = y >> 28;
    acc = 64'd1 << 32;
    for (int k = 0; k < 28; k++) begin
      if (y[27 - k]) begin
        prod = {64'd0, acc} * {64'd0, root_consts[k]};
        acc = prod[95:32];
      end
    end
    acc = (n > 32) ? 64'd0 : (acc >> n);
    scaled = (64'd65535 * acc) >> 32;
    return scaled[15:0];
  endfunction

  function bit [7:0] level_of(bit [8:0] slot);
    if (slot == 0) return master;
    return colour[slot - 1];
  endfunction

  function void write_reg(bit [2:0] idx, bit [11:0] data);
    if (idx == dgld_pkg::RegGamma) gamma_q8 = data;
    else if (idx <= 6) limit[idx - 1] = data[7:0];
  endfunction

  // Note one accepted slot write and queue the updates it causes
  function void note_input(bit [8:0] slot, bit [7:0] level);
    pwm_update_t u;
    int first;
    if (slot == 0) begin
      if (level == master) return;
      master = level;
      first = pending_updates.size();
      for (int i = 0; i < 6; i++) begin
        if (colour[i] != 0) begin
          u.pwm_index = 3'(i);
          u.compare_value = gamma_value(colour[i], master, limit[i]);
          u.last_of_run = 0;
          pending_updates.push_back(u);
        end
      end
      if (pending_updates.size() > first)
        pending_updates[pending_updates.size() - 1].last_of_run = 1;
    end else if (slot <= 6) begin
      if (level == colour[slot - 1]) return;
      colour[slot - 1] = level;
      u.pwm_index = 3'(slot - 9'd1);
      u.compare_value = gamma_value(level, master, limit[slot - 1]);
      u.last_of_run = 1;
      pending_updates.push_back(u);
    end
  endfunction

  // Check one output beat against the oldest queued update
  function void check_result(bit [2:0] idx, bit [15:0] cv, bit last);
    pwm_update_t u;
    int diff;
    if (pending_updates.size() == 0) begin
      $error("unexpected beat: pwm_index %0d compare_value %0d", idx, cv);
      errors++;
      return;
    end
    u = pending_updates.pop_front();
    if (u.pwm_index != idx) begin
      $error("pwm_index expected %0d actual %0d", u.pwm_index, idx);
      errors++;
    end
    // the block may differ by up to 2 LSB from the model's value
    diff = int'(u.compare_value) - int'(cv);
    if (diff > 2 || diff < -2) begin
      $error("compare_value expected %0d actual %0d", u.compare_value, cv);
      errors++;
    end
    if (u.last_of_run != last) begin
      $error("last_of_run expected %0d actual %0d", u.last_of_run, last);
      errors++;
    end
  endfunction
endclass

module tb_dmx_gamma_led_dimmer;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = 0;   // [8:0] slot, [16:9] level, zero fill
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;       // [2:0] pwm_index, [18:3] compare_value
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [11:0] cfg_data = 0;

  dimmer_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 0;
  int hold_cycles = 0;

  dmx_gamma_led_dimmer dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #50ms;
    $display("tb_dmx_gamma_led_dimmer: FAIL");
    $finish;
  end

  // Drive the receiver ready, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
        m_tready <= 0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check output beats
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[2:0], m_tdata[18:3], m_tlast);
  end

  task automatic send_slot(bit [8:0] slot, bit [7:0] level);
    s_tvalid <= 1;
    s_tdata <= {7'd0, level, slot};
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    sb.note_input(slot, level);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(bit [2:0] idx, bit [11:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold until every update is out and the block has settled
  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_slots(int count);
    bit [8:0] slot;
    bit [7:0] level;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) slot = 9'd0;
      else if (pick < 90) slot = 9'($urandom_range(1, 6));
      else slot = 9'($urandom_range(7, 511));
      level = ($urandom_range(99) < 15 && slot <= 6) ? sb.level_of(slot) : 8'($urandom);
      send_slot(slot, level);
    end
  endtask

  task automatic random_config(bit [11:0] gamma);
    write_reg(dgld_pkg::RegGamma, gamma);
    for (int i = 0; i < 6; i++) begin
      write_reg(dgld_pkg::RegLimit0 + 3'(i),
                ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, extremes, unchanged levels, ignored slots
    send_slot(1, 8'd255);
    send_slot(0, 8'd255);
    send_slot(1, 8'd255);
    send_slot(2, 8'd1);
    send_slot(6, 8'd128);
    send_slot(0, 8'd255);
    send_slot(0, 8'd1);
    send_slot(7, 8'd55);
    send_slot(9'd511, 8'd255);
    send_slot(9'd256, 8'd170);
    send_slot(1, 8'd0);
    send_slot(0, 8'd0);
    send_slot(3, 8'd85);
    send_slot(0, 8'd170);
    for (int i = 1; i <= 6; i++) send_slot(9'(i), 8'd0);
    send_slot(0, 8'd200);
    drain();

    // Gamma zero, one limit zero, one at full scale
    write_reg(dgld_pkg::RegGamma, 12'd0);
    write_reg(dgld_pkg::RegLimit0, 12'd0);
    write_reg(dgld_pkg::RegLimit0 + 3'd5, 12'd255);
    send_slot(1, 8'd200);
    send_slot(6, 8'd3);
    send_slot(4, 8'd99);
    send_slot(0, 8'd255);
    drain();

    // Random phases: sender idles lightly, then receiver does, then neither
    send_idle_pct = 8;
    recv_idle_pct = 47;
    random_config(12'd4095);
    hold_request = 1;
    random_slots(100);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 8;
    random_config(12'd1);
    random_slots(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config(12'($urandom_range(1, 4095)));
    write_reg(dgld_pkg::RegLimit0 + 3'd2, 12'd255);
    random_slots(100);
    drain();

    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("tb_dmx_gamma_led_dimmer: PASS");
    end else begin
      $display("tb_dmx_gamma_led_dimmer: FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/dgld_pkg.sv
hdl/dmx_gamma_led_dimmer.sv
tb/sv/tb_dmx_gamma_led_dimmer.sv
